// ===== hw/rtl/fth_pkg.sv =====
`timescale 1ns / 1ps
package fth_pkg;

  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  localparam int unsigned HASH_SEED = 32'd5381;

  // full five-tuple, ports and protocol packed as the stored key
  typedef struct packed {
    logic [63:0] shi;
    logic [63:0] slo;
    logic [63:0] dhi;
    logic [63:0] dlo;
    logic [39:0] pp;
  } key_t;

endpackage

// ===== hw/rtl/flow_tuple_hash_table.sv =====
`timescale 1ns / 1ps
// Flow table over the IPv6 five-tuple with chained buckets.
// Input channel in_*: one request (find, add/update, clear) per handshake,
//   accepted when in_valid is high and in_stall low. Command 3 is dropped.
// Output out_*: one result per request but command 3, held while out_stall high.
// Config channel cfg_*: bucket count, write only while idle.
// The front end holds a request in F_DIV for the hash and its modulo
//   (one remainder bit per cycle over the 32-bit hash) and takes no new
//   request until F_OUT has passed the current one on. The back end goes
//   through B_HEAD and B_RD, then B_CMP and B_RD per chain entry visited,
//   and raises out_valid in B_OUT: a hit enters it from B_CMP, a find miss
//   from B_RD, an insert or full add from B_WR, a clear from B_IDLE.
// Front and back overlap, so throughput is set by the slower of the two.
// Reset clears the bucket-head valid bits and the pool count; entry memory
//   keeps junk that is never read before written. A stalled output backs up
//   the back end, then the front end, then in_stall rises.
module flow_tuple_hash_table
  import fth_pkg::*;
#(
  parameter int NUM_BUCKETS = 64,
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_src_addr_hi,
  input  logic [63:0] in_src_addr_lo,
  input  logic [63:0] in_dst_addr_hi,
  input  logic [63:0] in_dst_addr_lo,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_proto,
  input  logic [15:0] in_flow_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_hit,
  output logic [15:0] out_found_value,
  output logic [5:0]  out_bucket_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_bucket_count
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int EW = $clog2(MAX_ENTRIES);

  logic [6:0]    bc_r;
  logic [BW:0]   nb;
  key_t          key;
  logic          q_valid, q_stall;
  logic [1:0]    q_cmd;
  key_t          q_key;
  logic [15:0]   q_val;
  logic [BW-1:0] q_bucket;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= 7'd64;
    end else if (cfg_valid) begin
      bc_r <= cfg_bucket_count;
    end
  end
  assign cfg_ready = 1'b1;

  // zero acts as one, oversize clamps to the built table
  always_comb begin
    if (bc_r == 7'd0) nb = (BW+1)'(1);
    else if (32'(bc_r) > NUM_BUCKETS) nb = (BW+1)'(NUM_BUCKETS);
    else nb = (BW+1)'(bc_r);
  end

  assign key = '{shi: in_src_addr_hi, slo: in_src_addr_lo, dhi: in_dst_addr_hi,
                 dlo: in_dst_addr_lo, pp: {in_src_port, in_dst_port, in_proto}};

  fth_front #(.BW(BW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_key(key),
    .in_val(in_flow_value), .nb, .q_valid, .q_stall, .q_cmd, .q_key, .q_val, .q_bucket
  );

  fth_back #(.NB(NUM_BUCKETS), .ME(MAX_ENTRIES), .BW(BW), .EW(EW)) u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_cmd, .q_key, .q_val, .q_bucket,
    .out_valid, .out_stall, .out_status, .out_hit, .out_found_value, .out_bucket_index
  );

endmodule

// ===== hw/rtl/fth_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests, folds the source address into a 32-bit hash and
// reduces it modulo the bucket count by restoring subtraction, one bit a cycle.
module fth_front
  import fth_pkg::*;
#(
  parameter int BW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_cmd,
  input  key_t          in_key,
  input  logic [15:0]   in_val,
  input  logic [BW:0]   nb,
  output logic          q_valid,
  input  logic          q_stall,
  output logic [1:0]    q_cmd,
  output key_t          q_key,
  output logic [15:0]   q_val,
  output logic [BW-1:0] q_bucket
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_OUT  = 3'b100
  } fstate_t;

  fstate_t     st_r, st_nxt;
  logic [31:0] h_r, h_nxt;
  logic [BW:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  cmd_r;
  key_t        key_r;
  logic [15:0] val_r;
  logic [BW+1:0] trial;
  logic [31:0] hash;

  assign hash = HASH_SEED ^ in_key.shi[63:32] ^ in_key.shi[31:0]
              ^ in_key.slo[63:32] ^ in_key.slo[31:0];
  assign trial = {rem_r, h_r[31]};

  always_comb begin
    st_nxt  = st_r;
    h_nxt   = h_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          h_nxt   = hash;
          rem_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = F_DIV;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, nb}) rem_nxt = (BW+1)'(trial - {1'b0, nb});
        else rem_nxt = trial[BW:0];
        h_nxt   = {h_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) st_nxt = F_OUT;
      end
      F_OUT: begin
        if (!q_stall) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    h_r   <= h_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (st_r == F_IDLE) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      val_r <= in_val;
    end
  end

  assign in_stall = (st_r != F_IDLE);
  assign q_valid  = (st_r == F_OUT);
  assign q_cmd    = cmd_r;
  assign q_key    = key_r;
  assign q_val    = val_r;
  assign q_bucket = rem_r[BW-1:0];

endmodule

// ===== hw/rtl/fth_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the chain in the entry memory and applies find/add/clear.
module fth_back
  import fth_pkg::*;
#(
  parameter int NB = 64,
  parameter int ME = 256,
  parameter int BW = 6,
  parameter int EW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_stall,
  input  logic [1:0]    q_cmd,
  input  key_t          q_key,
  input  logic [15:0]   q_val,
  input  logic [BW-1:0] q_bucket,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic          out_hit,
  output logic [15:0]   out_found_value,
  output logic [5:0]    out_bucket_index
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_HEAD = 6'b000010,
    B_RD   = 6'b000100,
    B_CMP  = 6'b001000,
    B_WR   = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  typedef struct packed {
    key_t        key;
    logic [15:0] val;
    logic        lv;
    logic [EW-1:0] link;
  } ent_t;

  logic [EW-1:0] head_mem [NB];
  logic [NB-1:0] head_v_r;
  ent_t          ent_mem  [ME];

  bstate_t       st_r;
  logic [EW:0]   used_r;
  logic [EW-1:0] cur_r;
  logic          cv_r;
  logic [EW:0]   steps_r;
  ent_t          rd_r;
  logic [EW-1:0] hd_r;
  logic [1:0]    cmd_r;
  key_t          key_r;
  logic [15:0]   val_r;
  logic [BW-1:0] b_r;
  logic [2:0]    ost_r;
  logic          ohit_r;
  logic [15:0]   oval_r;
  logic [5:0]    obkt_r;
  logic          wr_en;
  logic [EW-1:0] wr_addr;
  ent_t          wr_data;

  // head read follows the incoming bucket while idle so it is ready in B_HEAD
  always_ff @(posedge clk) begin
    hd_r <= head_mem[(st_r == B_IDLE) ? q_bucket : b_r];
    rd_r <= ent_mem[cur_r];
    if (wr_en) ent_mem[wr_addr] <= wr_data;
    if (st_r == B_WR && used_r < (EW+1)'(ME)) head_mem[b_r] <= used_r[EW-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = used_r[EW-1:0];
    wr_data = '{key: key_r, val: val_r, lv: head_v_r[b_r], link: hd_r};
    if (st_r == B_CMP && rd_r.key == key_r && cmd_r == CMD_ADD) begin
      wr_en   = 1'b1;
      wr_addr = cur_r;
      wr_data = rd_r;
      wr_data.val = val_r;
    end else if (st_r == B_WR && used_r < (EW+1)'(ME)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      head_v_r <= '0;
      used_r   <= '0;
    end else begin
      unique case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            key_r <= q_key;
            val_r <= q_val;
            b_r   <= q_bucket;
            obkt_r <= 6'(q_bucket);
            ohit_r <= 1'b0;
            oval_r <= '0;
            if (q_cmd == CMD_CLEAR) begin
              head_v_r <= '0;
              used_r   <= '0;
              ost_r    <= ST_CLEARED;
              obkt_r   <= '0;
              st_r     <= B_OUT;
            end else if (q_cmd == CMD_NONE) begin
              st_r <= B_IDLE;
            end else begin
              st_r <= B_HEAD;
            end
          end
        end
        B_HEAD: begin
          cur_r   <= hd_r;
          cv_r    <= head_v_r[b_r];
          steps_r <= '0;
          st_r    <= B_RD;
        end
        B_RD: begin
          if (!cv_r || steps_r == (EW+1)'(ME)) begin
            if (cmd_r == CMD_FIND) begin
              ost_r <= ST_MISS;
              st_r  <= B_OUT;
            end else begin
              st_r <= B_WR;
            end
          end else begin
            st_r <= B_CMP;
          end
        end
        B_CMP: begin
          if (rd_r.key == key_r) begin
            ohit_r <= 1'b1;
            if (cmd_r == CMD_FIND) begin
              ost_r  <= ST_FOUND;
              oval_r <= rd_r.val;
            end else begin
              ost_r  <= ST_UPDATED;
              oval_r <= val_r;
            end
            st_r <= B_OUT;
          end else begin
            cur_r   <= rd_r.link;
            cv_r    <= rd_r.lv;
            steps_r <= steps_r + (EW+1)'(1);
            st_r    <= B_RD;
          end
        end
        B_WR: begin
          if (used_r < (EW+1)'(ME)) begin
            head_v_r[b_r] <= 1'b1;
            used_r <= used_r + (EW+1)'(1);
            ost_r  <= ST_INSERTED;
          end else begin
            ost_r <= ST_FULL;
          end
          st_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_stall) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign q_stall          = (st_r != B_IDLE);
  assign out_valid        = (st_r == B_OUT);
  assign out_status       = ost_r;
  assign out_hit          = ohit_r;
  assign out_found_value  = oval_r;
  assign out_bucket_index = obkt_r;

endmodule

// ===== tb/sv/tb_flow_tuple_hash_table.sv =====
`timescale 1ns / 1ps
module tb_flow_tuple_hash_table;
  import fth_pkg::*;

  localparam int NBKT = 64;
  localparam int NENT = 256;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_FIND;
  logic [63:0] in_src_addr_hi = '0;
  logic [63:0] in_src_addr_lo = '0;
  logic [63:0] in_dst_addr_hi = '0;
  logic [63:0] in_dst_addr_lo = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [7:0]  in_proto = '0;
  logic [15:0] in_flow_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic        out_hit;
  logic [15:0] out_found_value;
  logic [5:0]  out_bucket_index;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_bucket_count = 7'd64;

  flow_tuple_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_src_addr_hi(in_src_addr_hi), .in_src_addr_lo(in_src_addr_lo),
    .in_dst_addr_hi(in_dst_addr_hi), .in_dst_addr_lo(in_dst_addr_lo),
    .in_src_port(in_src_port), .in_dst_port(in_dst_port), .in_proto(in_proto),
    .in_flow_value(in_flow_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_hit(out_hit), .out_found_value(out_found_value),
    .out_bucket_index(out_bucket_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_bucket_count(cfg_bucket_count)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    status_t     status;
    logic        hit;
    logic [15:0] value;
    logic [5:0]  bucket;
  } lookup_result_t;

  // shadow flow table
  key_t        pool_key [NENT];
  logic [15:0] pool_val [NENT];
  int          pool_link [NENT];   // -1 ends a chain
  int          chain_head [NBKT];  // -1 empty
  int          pool_used;
  logic [6:0]  bucket_reg;

  lookup_result_t pending_results[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  bit  hold_off = 1'b0;

  // first tuples added (up to 64), reused so finds and updates hit
  key_t known_keys[$];

  function automatic int active_buckets();
    int n;
    n = bucket_reg;
    if (n == 0) n = 1;
    if (n > NBKT) n = NBKT;
    return n;
  endfunction

  function automatic int hash_bucket(logic [63:0] shi, logic [63:0] slo);
    logic [31:0] h;
    h = HASH_SEED[31:0] ^ shi[63:32] ^ shi[31:0] ^ slo[63:32] ^ slo[31:0];
    return int'(h % active_buckets());
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < NBKT; i++) chain_head[i] = -1;
    pool_used = 0;
  endfunction

  // computes the result of one request and updates the shadow table
  function automatic void predict_lookup(cmd_t cmd, key_t k, logic [15:0] fval);
    lookup_result_t r;
    int b;
    int cur;
    if (cmd == CMD_NONE) return;
    if (cmd == CMD_CLEAR) begin
      table_clear();
      r.status = ST_CLEARED; r.hit = 0; r.value = '0; r.bucket = '0;
      pending_results.push_back(r);
      return;
    end
    b = hash_bucket(k.shi, k.slo);
    cur = chain_head[b];
    while (cur >= 0 && pool_key[cur] != k) cur = pool_link[cur];
    r.bucket = b[5:0];
    if (cmd == CMD_FIND) begin
      r.status = (cur >= 0) ? ST_FOUND : ST_MISS;
      r.hit = (cur >= 0);
      r.value = (cur >= 0) ? pool_val[cur] : 16'd0;
    end else if (cur >= 0) begin
      pool_val[cur] = fval;
      r.status = ST_UPDATED; r.hit = 1; r.value = fval;
    end else if (pool_used >= NENT) begin
      r.status = ST_FULL; r.hit = 0; r.value = '0;
    end else begin
      pool_key[pool_used] = k;
      pool_val[pool_used] = fval;
      pool_link[pool_used] = chain_head[b];
      chain_head[b] = pool_used;
      pool_used++;
      r.status = ST_INSERTED; r.hit = 0; r.value = '0;
    end
    pending_results.push_back(r);
  endfunction

  // sends one request, predicting at acceptance; valid stays up until the
  // next request or an idle cycle replaces it
  task automatic send_request(cmd_t cmd, key_t k, logic [15:0] fval);
    while (sender_idles && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_src_addr_hi <= k.shi; in_src_addr_lo <= k.slo;
    in_dst_addr_hi <= k.dhi; in_dst_addr_lo <= k.dlo;
    in_src_port <= k.pp[39:24]; in_dst_port <= k.pp[23:8]; in_proto <= k.pp[7:0];
    in_flow_value <= fval;
    do @(posedge clk); while (in_stall);
    predict_lookup(cmd, k, fval);
    if (cmd == CMD_ADD && known_keys.size() < 64) known_keys.push_back(k);
    @(negedge clk);
  endtask

  function automatic key_t random_key();
    key_t k;
    k.shi = {$urandom, $urandom}; k.slo = {$urandom, $urandom};
    k.dhi = {$urandom, $urandom}; k.dlo = {$urandom, $urandom};
    k.pp = {8'($urandom_range(255)), $urandom};
    return k;
  endfunction

  // pick a remembered tuple most of the time
  function automatic key_t pick_key();
    if (known_keys.size() > 0 && $urandom_range(99) < 60)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return random_key();
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_bucket_count(logic [6:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_bucket_count <= v;
    do @(posedge clk); while (!cfg_ready);
    bucket_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    key_t k;
    k = '0;
    send_request(CMD_FIND, k, 16'h0);
    send_request(CMD_ADD, k, 16'hffff);
    send_request(CMD_FIND, k, 16'h0);
    send_request(CMD_ADD, k, 16'h0000);
    send_request(CMD_FIND, k, 16'h1234);
    k = '1;
    send_request(CMD_ADD, k, 16'ha5a5);
    send_request(CMD_FIND, k, 16'h0);
    // same source, different rest of tuple: same chain, distinct flows
    k.pp = '0;
    send_request(CMD_ADD, k, 16'h5a5a);
    k.dlo = '0;
    send_request(CMD_FIND, k, 16'h0);
    send_request(CMD_NONE, k, 16'h0);   // dropped, no result
    send_request(CMD_CLEAR, k, 16'hffff);
    send_request(CMD_FIND, '1, 16'h0);
  endtask

  // single bucket: every flow lands on one long chain
  task automatic test_one_bucket_chain();
    write_bucket_count(7'd0);
    for (int i = 0; i < 12; i++) send_request(CMD_ADD, random_key(), 16'($urandom));
    for (int i = 0; i < 12; i++) send_request(CMD_FIND, pick_key(), 16'h0);
    // stale entries may be lost under another bucket count
    write_bucket_count(7'd127);
    for (int i = 0; i < 10; i++) send_request(CMD_FIND, pick_key(), 16'h0);
    send_request(CMD_CLEAR, '0, 16'h0);
    known_keys.delete();
  endtask

  // fill the pool past its size so adds report full
  task automatic test_pool_full();
    write_bucket_count(7'd64);
    for (int i = 0; i < NENT + 10; i++)
      send_request(CMD_ADD, random_key(), 16'($urandom));
    for (int i = 0; i < 20; i++)
      send_request($urandom_range(1) ? CMD_ADD : CMD_FIND, pick_key(), 16'($urandom));
    send_request(CMD_CLEAR, '0, 16'h0);
    known_keys.delete();
  endtask

  task automatic random_phase(int n);
    cmd_t c;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      c = (r < 40) ? CMD_FIND : (r < 95) ? CMD_ADD : (r < 97) ? CMD_CLEAR : CMD_NONE;
      send_request(c, pick_key(), 16'($urandom));
      if (c == CMD_CLEAR) known_keys.delete();
    end
  endtask

  task automatic test_random_settings();
    write_bucket_count(7'd1);
    random_phase(150);
    write_bucket_count(7'd37);
    random_phase(200);
    // no idling on either side
    sender_idles = 1'b0; receiver_idles = 1'b0;
    random_phase(150);
    sender_idles = 1'b1; receiver_idles = 1'b1;
    write_bucket_count(7'd64);
    random_phase(370);
  endtask

  // receiver stops long enough for the block to back up
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    random_phase(40);
    write_bucket_count(7'd7);
    random_phase(50);
  endtask

  // receiver stall generator
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= receiver_idles && ($urandom_range(99) < 33);
  end

  // result checker
  always @(posedge clk) begin
    lookup_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", out_status);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status || out_hit !== e.hit ||
            out_found_value !== e.value || out_bucket_index !== e.bucket) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st=%0d hit=%0d val=%h bkt=%0d got st=%0d hit=%0d val=%h bkt=%0d",
                     e.status, e.hit, e.value, e.bucket,
                     out_status, out_hit, out_found_value, out_bucket_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    bucket_reg = 7'd64;
    table_clear();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_one_bucket_chain();
    test_pool_full();
    test_random_settings();
    test_backpressure();
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
